@@ rtl/core/axis_angle_from_vectors_core_macros.svh @@
// assertion macros for the axis/angle core
// no dependencies
`ifndef AXIS_ANGLE_FROM_VECTORS_CORE_MACROS_SVH
`define AXIS_ANGLE_FROM_VECTORS_CORE_MACROS_SVH
// implication checked on every clock, off during reset
`define AAV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AAV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/aav_pkg.sv @@
// package for the axis/angle core: constants, stage types, cordic table
// no dependencies
package aav_pkg;
  localparam int FracBitsDefault = 14;
  localparam int CordicSteps = 24;
  localparam int EpsQ30 = 1074;
  localparam logic [14:0] PiQ13 = 15'd25736;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0: r = 30'd843314856;
        5'd1: r = 30'd497837829;
        5'd2: r = 30'd263043836;
        5'd3: r = 30'd133525158;
        5'd4: r = 30'd67021686;
        5'd5: r = 30'd33543515;
        5'd6: r = 30'd16775850;
        5'd7: r = 30'd8388437;
        5'd8: r = 30'd4194282;
        5'd9: r = 30'd2097149;
        5'd10: r = 30'd1048575;
        5'd11: r = 30'd524287;
        5'd12: r = 30'd262143;
        5'd13: r = 30'd131071;
        5'd14: r = 30'd65535;
        5'd15: r = 30'd32767;
        5'd16: r = 30'd16383;
        5'd17: r = 30'd8191;
        5'd18: r = 30'd4095;
        5'd19: r = 30'd2047;
        5'd20: r = 30'd1023;
        5'd21: r = 30'd511;
        5'd22: r = 30'd255;
        5'd23: r = 30'd127;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

  // side data carried along the angle pipeline
  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               degenerate;
    logic               dot_neg;
  } aav_side_t;
endpackage

@@ rtl/core/aav_front.sv @@
// front end: cross, dot, squared length, clamp to q60, fallback axis
// depends on aav_pkg
module aav_front import aav_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] ax, ay, az, bx, by, bz,
  output logic               out_valid,
  output logic [60:0]        sq,
  output logic               clamp,
  output aav_side_t          side,
  output aav_side_t          fb
);
  localparam int F4 = 4 * FRAC_BITS;
  localparam int F2 = 2 * FRAC_BITS;
  localparam logic [63:0] Lim = ((64'd1 << F2) / 64'd1000000000000) +
      (((64'd1 << F2) % 64'd1000000000000) != 0 ? 64'd1 : 64'd0);

  logic v1, v2, v3;
  logic signed [31:0] p1 [0:9];
  logic signed [32:0] cx, cy, cz;
  logic signed [33:0] dot;
  logic signed [15:0] ax1, ay1, az1;
  logic [65:0] cx2, cy2, cz2;
  logic signed [32:0] cx2r, cy2r, cz2r;
  logic dneg2;
  logic [31:0] s2a;
  logic signed [15:0] ax2, ay2, az2;
  logic [67:0] ssum;
  logic [60:0] sq3;
  logic clamp3;
  aav_side_t side3;
  logic signed [32:0] ry, rz;

  function automatic logic signed [15:0] sat(input logic signed [34:0] v);
    if (v > 35'sd32767) return 16'sh7fff;
    if (v < -35'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= ay * bz; p1[1] <= az * by;
      p1[2] <= az * bx; p1[3] <= ax * bz;
      p1[4] <= ax * by; p1[5] <= ay * bx;
      p1[6] <= ax * bx; p1[7] <= ay * by; p1[8] <= az * bz;
      p1[9] <= 32'(az) * 32'(az) + 32'(ax) * 32'(ax);
      ax1 <= ax; ay1 <= ay; az1 <= az;
    end
  end

  assign cx = 33'(p1[0]) - 33'(p1[1]);
  assign cy = 33'(p1[2]) - 33'(p1[3]);
  assign cz = 33'(p1[4]) - 33'(p1[5]);
  assign dot = 34'(p1[6]) + 34'(p1[7]) + 34'(p1[8]);

  always_ff @(posedge clk) begin
    if (en) begin
      cx2 <= 66'(cx * cx); cy2 <= 66'(cy * cy); cz2 <= 66'(cz * cz);
      cx2r <= cx; cy2r <= cy; cz2r <= cz;
      dneg2 <= dot < 0;
      s2a <= p1[9];
      ax2 <= ax1; ay2 <= ay1; az2 <= az1;
    end
  end

  assign ssum = 68'(cx2) + 68'(cy2) + 68'(cz2);

  always_comb begin
    clamp3 = (F4 <= 63) && (ssum >= (68'd1 << F4));
    if (F4 <= 60) sq3 = 61'(ssum << (60 - F4));
    else sq3 = 61'(ssum >> (F4 - 60));
    side3.dot_neg = dneg2;
    side3.degenerate = 1'b0;
    side3.axis_x = sat(35'(cx2r + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    side3.axis_y = sat(35'(cy2r + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    side3.axis_z = sat(35'(cz2r + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (64'(s2a) >= Lim) begin
      // fallback stored in fb, chosen later when length is tiny
      ry = 33'(az2);
      rz = -33'(ax2);
    end else begin
      ry = -33'(ay2);
      rz = 33'(ax2);
    end
  end

  // fallback axis packed in a second copy
  aav_side_t fb3;
  always_comb begin
    fb3.dot_neg = dneg2;
    fb3.degenerate = 1'b1;
    if (64'(s2a) >= Lim) begin
      fb3.axis_x = sat(35'(ry)); fb3.axis_y = 16'sd0; fb3.axis_z = sat(35'(rz));
    end else begin
      fb3.axis_x = sat(35'(ry)); fb3.axis_y = sat(35'(rz)); fb3.axis_z = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= sq3; clamp <= clamp3; side <= side3; fb <= fb3;
    end
  end

  assign out_valid = v3;
endmodule

@@ rtl/core/aav_sqrt.sv @@
// pipelined integer square root and cordic angle with fallback select
// depends on aav_pkg
module aav_sqrt import aav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [60:0] sq,
  input  logic        clamp,
  input  aav_side_t   side,
  input  aav_side_t   fb,
  output logic        out_valid,
  output aav_side_t   res,
  output logic [14:0] angle
);
  localparam int Ns = 31;
  localparam int Nc = 31;
  localparam int Nt = 2 * Ns + 2 + CordicSteps + 1;

  // stage arrays for square root of sin
  logic [62:0] rv [0:Ns];
  logic [62:0] rr [0:Ns];
  logic        cl [0:Ns];
  aav_side_t   sd [0:Ns];
  aav_side_t   fd [0:Ns];
  logic        vs [0:Nt];

  always_comb begin
    rv[0] = 63'(sq); rr[0] = '0; cl[0] = clamp; sd[0] = side; fd[0] = fb;
  end

  for (genvar k = 0; k < Ns; k++) begin : g_s
    logic [62:0] bitv, t;
    assign bitv = 63'd1 << (60 - 2 * k);
    assign t = rr[k] + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rv[k] >= t) begin
          rv[k+1] <= rv[k] - t; rr[k+1] <= (rr[k] >> 1) + bitv;
        end else begin
          rv[k+1] <= rv[k]; rr[k+1] <= rr[k] >> 1;
        end
        cl[k+1] <= cl[k]; sd[k+1] <= sd[k]; fd[k+1] <= fd[k];
      end
    end
  end

  // choose s, then square it
  logic [30:0] s_a;
  logic [62:0] ss;
  logic [30:0] s_b;
  aav_side_t sdb;
  logic degb;
  assign s_a = cl[Ns] ? 31'h40000000 : rr[Ns][30:0];
  always_ff @(posedge clk) begin
    if (en) begin
      s_b <= s_a;
      ss <= 63'(s_a * s_a);
      degb <= 32'(s_a) < EpsQ30;
      sdb <= (32'(s_a) < EpsQ30) ? fd[Ns] : sd[Ns];
    end
  end

  // square root of cosine
  logic [62:0] cv [0:Nc];
  logic [62:0] cr [0:Nc];
  logic [30:0] cs [0:Nc];
  logic        cd [0:Nc];
  aav_side_t   cq [0:Nc];
  always_ff @(posedge clk) begin
    if (en) begin
      cv[0] <= (63'd1 << 60) - ss; cr[0] <= '0; cs[0] <= s_b;
      cd[0] <= degb; cq[0] <= sdb;
    end
  end
  for (genvar k = 0; k < Nc; k++) begin : g_c
    logic [62:0] bitv, t;
    assign bitv = 63'd1 << (60 - 2 * k);
    assign t = cr[k] + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cv[k] >= t) begin
          cv[k+1] <= cv[k] - t; cr[k+1] <= (cr[k] >> 1) + bitv;
        end else begin
          cv[k+1] <= cv[k]; cr[k+1] <= cr[k] >> 1;
        end
        cs[k+1] <= cs[k]; cd[k+1] <= cd[k]; cq[k+1] <= cq[k];
      end
    end
  end

  // cordic vectoring
  logic signed [33:0] xx [0:CordicSteps];
  logic signed [33:0] yy [0:CordicSteps];
  logic signed [33:0] zz [0:CordicSteps];
  logic               kd [0:CordicSteps];
  aav_side_t          kq [0:CordicSteps];
  always_comb begin
    xx[0] = 34'(cr[Nc][31:0]); yy[0] = 34'(cs[Nc]); zz[0] = '0;
    kd[0] = cd[Nc]; kq[0] = cq[Nc];
  end
  for (genvar i = 0; i < CordicSteps; i++) begin : g_k
    logic signed [33:0] dx, dy, at;
    assign dx = yy[i] >>> i;
    assign dy = xx[i] >>> i;
    assign at = 34'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (yy[i] > 0) begin
          xx[i+1] <= xx[i] + dx; yy[i+1] <= yy[i] - dy; zz[i+1] <= zz[i] + at;
        end else begin
          xx[i+1] <= xx[i] - dx; yy[i+1] <= yy[i] + dy; zz[i+1] <= zz[i] - at;
        end
        kd[i+1] <= kd[i]; kq[i+1] <= kq[i];
      end
    end
  end

  logic [33:0] zp;
  logic [16:0] aq;
  logic [14:0] a0, a1;
  assign zp = zz[CordicSteps] < 0 ? 34'd0 : 34'(zz[CordicSteps]);
  assign aq = 17'((zp + 34'd65536) >> 17);
  assign a0 = kd[CordicSteps] ? 15'd0 : (aq > 17'(PiQ13) ? PiQ13 : aq[14:0]);
  assign a1 = kq[CordicSteps].dot_neg ? PiQ13 - a0 : a0;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= a1;
      res <= kq[CordicSteps];
    end
  end

  assign vs[0] = in_valid;
  for (genvar k = 0; k < Nt; k++) begin : g_v
    always_ff @(posedge clk) begin
      if (rst) vs[k+1] <= 1'b0;
      else if (en) vs[k+1] <= vs[k];
    end
  end
  assign out_valid = vs[Nt];
endmodule

@@ rtl/core/axis_angle_from_vectors_core.sv @@
// top level of the axis/angle core: stream ports, pipeline enable, output stage
// depends on aav_pkg, aav_front, aav_sqrt, axis_angle_from_vectors_core_macros.svh
//
// channel  dir  tdata fields (low bit up)                                tuser
// s_axis   in   first_x, first_y, first_z, second_x, second_y, second_z  none
// m_axis   out  axis_x, axis_y, axis_z, angle, degenerate (64 bits)       none
//
// one transaction per cycle unless the output stalls; 3 front stages, two 31-stage
// square root pipelines with two stages between them, 24 cordic stages and
// the output register
// the whole pipeline advances while the output is empty or being taken
// reset clears all valid bits; data registers are not reset
`include "axis_angle_from_vectors_core_macros.svh"
module axis_angle_from_vectors_core import aav_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // first_x, first_y, first_z, second_x, second_y, second_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // axis_x, axis_y, axis_z, angle, degenerate
);
  logic en;
  logic fv, sv;
  logic [60:0] sq;
  logic clamp;
  aav_side_t side, fb, res;
  logic [14:0] angle;
  logic deg_pos, m_stall;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  aav_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en, .in_valid(s_axis_tvalid),
    .ax(s_axis_tdata[15:0]), .ay(s_axis_tdata[31:16]), .az(s_axis_tdata[47:32]),
    .bx(s_axis_tdata[63:48]), .by(s_axis_tdata[79:64]), .bz(s_axis_tdata[95:80]),
    .out_valid(fv), .sq, .clamp, .side, .fb
  );

  aav_sqrt u_sqrt (
    .clk, .rst, .en, .in_valid(fv), .sq, .clamp, .side, .fb,
    .out_valid(sv), .res, .angle
  );

  assign m_axis_tvalid = sv;
  assign m_axis_tdata = {res.degenerate, angle, res.axis_z, res.axis_y, res.axis_x};

  assign deg_pos = res.degenerate && !res.dot_neg;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `AAV_ASSERT_IMP(a_deg_angle, m_axis_tvalid && deg_pos, angle == 15'd0, "degenerate angle not zero")
  `AAV_ASSERT_IMP(a_angle_rng, m_axis_tvalid, angle <= PiQ13, "angle above pi")
  `AAV_ASSERT_NEXT(a_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
